// ===== hdl/cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmm_pkg: complex matrix multiply shared definitions
// Sizes, operation and register codes, and the sequencer microcode table.
// ----------------------------------------------------------------------------
package cmm_pkg;

    // Sizes
    localparam int MAX_DIM    = 8;
    localparam int ELEM_W     = 16;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int OP_W       = 2;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int RES_W      = 2 * ELEM_W + 4;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int PAIR_W     = 2 * ELEM_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WR_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

    // Microcode addresses
    typedef logic [2:0] t_step;
    localparam t_step S_IDLE = 3'd0;
    localparam t_step S_ELEM = 3'd1;
    localparam t_step S_READ = 3'd2;
    localparam t_step S_MUL  = 3'd3;
    localparam t_step S_ACC  = 3'd4;
    localparam t_step S_EMIT = 3'd5;

    // Sequencing modes
    typedef enum logic [2:0] {
        SQ_NEXT,        // fall through to the next step
        SQ_DISPATCH,    // wait for a transaction, jump on a run with nonzero rows and columns
        SQ_SKIP,        // jump when the inner size is zero
        SQ_LOOP,        // jump back while inner terms remain
        SQ_EMIT         // hold until output free, then jump or finish
    } t_seq;

    typedef struct packed {
        t_seq  seq;
        t_step target;
        logic  clr_acc;
        logic  rd;
        logic  mul;
        logic  acc;
        logic  emit;
    } t_uword;

    // Control store
    function automatic t_uword cmm_ucode(input t_step step);
        t_uword uw;
        uw = '{seq: SQ_NEXT, target: S_IDLE, clr_acc: 1'b0, rd: 1'b0,
               mul: 1'b0, acc: 1'b0, emit: 1'b0};
        case (step)
            S_IDLE: begin
                uw.seq    = SQ_DISPATCH;
                uw.target = S_ELEM;
            end
            S_ELEM: begin
                uw.seq     = SQ_SKIP;
                uw.target  = S_EMIT;
                uw.clr_acc = 1'b1;
            end
            S_READ: begin
                uw.rd = 1'b1;
            end
            S_MUL: begin
                uw.mul = 1'b1;
            end
            S_ACC: begin
                uw.seq    = SQ_LOOP;
                uw.target = S_READ;
                uw.acc    = 1'b1;
            end
            S_EMIT: begin
                uw.seq    = SQ_EMIT;
                uw.target = S_ELEM;
                uw.emit   = 1'b1;
            end
            default: begin
                uw.seq    = SQ_NEXT;
                uw.target = S_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== hdl/cmm_ram.sv =====
// ----------------------------------------------------------------------------
// cmm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/complex_matrix_multiply_top.sv =====
// ----------------------------------------------------------------------------
// complex_matrix_multiply_top: complex matrix multiply C = A x B
// Loads elements of A and B into on-chip stores and streams out C.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): operation 0 loads an element of
//   A, operation 1 an element of B, at (i_elem_row, i_elem_col); operation 2
//   runs the product. Unused codes are dropped.
//   Output channel (o_out_valid / i_out_stall): one transaction per element
//   of C in row-major order, o_out_last set on the final element.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): registers
//   left_rows, inner_size, right_cols; values above the store size clamp.
//   Write them only while the block is idle.
// Sequencing:
//   A microcoded sequencer runs a RAM read, multiply and accumulate step
//   for each inner term, and an element step and an emit step for each
//   element of C. The input stalls for the whole run.
// Reset: synchronous; dimensions return to their maximum, stores keep their
//   contents (undefined until loaded). When the receiver stalls, the result
//   register holds and the sequencer waits in its emit step.
// ----------------------------------------------------------------------------
module complex_matrix_multiply_top
    import cmm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [IDX_W-1:0]        i_elem_row,
    input  logic [IDX_W-1:0]        i_elem_col,
    input  logic signed [ELEM_W-1:0] i_value_re,
    input  logic signed [ELEM_W-1:0] i_value_im,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [RES_W-1:0] o_out_re,
    output logic signed [RES_W-1:0] o_out_im,
    output logic                    o_out_last,
    // config channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // Control state
    t_step            r_upc, n_upc;
    logic             r_out_valid;
    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic [IDX_W-1:0] r_i, r_j;
    logic [DIM_W-1:0] r_k;

    // Datapath registers
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [RES_W-1:0]  r_acc_re, r_acc_im;

    t_uword            uw;
    logic              in_acc, cfg_acc, out_free, emit_go;
    logic              last_i, last_j;
    logic              in_addr_ok, we_left, we_right;
    logic [ADDR_W-1:0] waddr, raddr_left, raddr_right;
    logic [PAIR_W-1:0] wdata, rdata_left, rdata_right;
    logic [DIM_W-1:0]  cfg_dim;
    logic signed [ELEM_W-1:0] a_re, a_im, b_re, b_im;

    // Handshakes
    assign o_in_stall  = (r_upc != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    assign uw      = cmm_ucode(r_upc);
    assign emit_go = uw.emit && out_free;

    // Position in the result
    assign last_i = (DIM_W'(r_i) + DIM_W'(1)) == r_rows;
    assign last_j = (DIM_W'(r_j) + DIM_W'(1)) == r_cols;

    // Clamp a dimension write to the store size
    assign cfg_dim = (int'(i_cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_cfg_data);

    // Store write side
    assign in_addr_ok = (int'(i_elem_row) < MAX_DIM) && (int'(i_elem_col) < MAX_DIM);
    assign we_left    = in_acc && in_addr_ok && (i_operation == OP_WR_LEFT);
    assign we_right   = in_acc && in_addr_ok && (i_operation == OP_WR_RIGHT);
    assign waddr      = {i_elem_row, i_elem_col};
    assign wdata      = {i_value_re, i_value_im};

    // Store read side: A at (i, k), B at (k, j)
    assign raddr_left  = {r_i, r_k[IDX_W-1:0]};
    assign raddr_right = {r_k[IDX_W-1:0], r_j};

    cmm_ram #(.WIDTH(PAIR_W), .DEPTH(DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (we_left),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_left),
        .o_rdata (rdata_left)
    );

    cmm_ram #(.WIDTH(PAIR_W), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (we_right),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_right),
        .o_rdata (rdata_right)
    );

    assign a_re = rdata_left[PAIR_W-1:ELEM_W];
    assign a_im = rdata_left[ELEM_W-1:0];
    assign b_re = rdata_right[PAIR_W-1:ELEM_W];
    assign b_im = rdata_right[ELEM_W-1:0];

    // Sequencer next step
    always_comb begin
        n_upc = r_upc;
        case (uw.seq)
            SQ_NEXT: begin
                n_upc = r_upc + t_step'(1);
            end
            SQ_DISPATCH: begin
                if (in_acc && i_operation == OP_RUN && r_rows != '0 && r_cols != '0) begin
                    n_upc = uw.target;
                end
            end
            SQ_SKIP: begin
                n_upc = (r_inner == '0) ? uw.target : r_upc + t_step'(1);
            end
            SQ_LOOP: begin
                n_upc = (r_k != r_inner) ? uw.target : r_upc + t_step'(1);
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_upc = (last_i && last_j) ? S_IDLE : uw.target;
                end
            end
            default: begin
                n_upc = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rows      <= DIM_W'(MAX_DIM);
            r_inner     <= DIM_W'(MAX_DIM);
            r_cols      <= DIM_W'(MAX_DIM);
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            r_upc <= n_upc;

            // dimension registers
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_LEFT_ROWS:  r_rows  <= cfg_dim;
                    REG_INNER_SIZE: r_inner <= cfg_dim;
                    REG_RIGHT_COLS: r_cols  <= cfg_dim;
                    default: ;
                endcase
            end

            // element counters
            if (r_upc == S_IDLE) begin
                r_i <= '0;
                r_j <= '0;
            end else if (emit_go) begin
                if (last_j) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end

            // inner term counter
            if (uw.clr_acc) begin
                r_k <= '0;
            end else if (uw.rd) begin
                r_k <= r_k + DIM_W'(1);
            end

            // result register valid
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Multiply, accumulate and result payload
    always_ff @(posedge i_clk) begin
        if (uw.mul) begin
            r_p_rr <= a_re * b_re;
            r_p_ii <= a_im * b_im;
            r_p_ri <= a_re * b_im;
            r_p_ir <= a_im * b_re;
        end
        if (uw.clr_acc) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (uw.acc) begin
            r_acc_re <= r_acc_re + RES_W'(r_p_rr) - RES_W'(r_p_ii);
            r_acc_im <= r_acc_im + RES_W'(r_p_ri) + RES_W'(r_p_ir);
        end
        if (emit_go) begin
            o_out_row  <= r_i;
            o_out_col  <= r_j;
            o_out_re   <= r_acc_re;
            o_out_im   <= r_acc_im;
            o_out_last <= last_i && last_j;
        end
    end

    // Checks
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_RUN && r_rows != '0 && r_cols != '0)
        |=> (r_upc == S_ELEM))
        else $error("run transaction did not start the element sequence");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && last_i && last_j) |=> (r_upc == S_IDLE && o_out_last))
        else $error("final element did not return the sequencer to idle");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_upc) == S_EMIT))
        else $error("result loaded outside the emit step");

endmodule
